// ===== hw/rtl/cmds_pkg.sv =====
package cmds_pkg;

  localparam int FaceSize  = 128;
  localparam int NumFaces  = 6;
  localparam int ColW      = 7;
  localparam int AddrW     = 17;
  localparam int Depth     = NumFaces * FaceSize * FaceSize;
  localparam int NumW      = 24;
  localparam int DenW      = 17;
  localparam int QuoW      = 8;
  localparam int DivStages = 4;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [2:0] FACE_POSX = 3'd0;
  localparam logic [2:0] FACE_POSY = 3'd1;
  localparam logic [2:0] FACE_POSZ = 3'd2;
  localparam logic [2:0] FACE_NEGX = 3'd3;
  localparam logic [2:0] FACE_NEGY = 3'd4;
  localparam logic [2:0] FACE_NEGZ = 3'd5;

  // Sideband that travels beside the divider stages
  typedef struct packed {
    logic             valid;
    logic             cmd;
    logic             wr_ok;
    logic [AddrW-1:0] wr_addr;
    logic [23:0]      wr_data;
    logic             zero;
    logic [2:0]       face;
  } side_t;

  // One restoring step: try to take den << sh from the remainder
  function automatic logic [NumW:0] div_step(input logic [NumW-1:0] rem,
                                              input logic [DenW-1:0] den,
                                              input logic [2:0] sh);
    logic [NumW:0] shifted;
    logic [NumW:0] diff;
    begin
      shifted = {{(NumW+1-DenW){1'b0}}, den} << sh;
      diff    = {1'b0, rem} - shifted;
      if (diff[NumW]) begin
        div_step = {1'b0, rem};
      end else begin
        div_step = {1'b1, diff[NumW-1:0]};
      end
    end
  endfunction

endpackage

// ===== hw/rtl/cmds_div.sv =====
// Pipelined restoring divider, two quotient bits per stage
module cmds_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cmds_pkg::NumW-1:0]     num,
  input  logic [cmds_pkg::DenW-1:0]     den,
  output logic [cmds_pkg::QuoW-1:0]     quo
);

  logic [cmds_pkg::NumW-1:0] rem_q [cmds_pkg::DivStages];
  logic [cmds_pkg::DenW-1:0] den_q [cmds_pkg::DivStages];
  logic [cmds_pkg::QuoW-1:0] quo_q [cmds_pkg::DivStages];

  logic [cmds_pkg::NumW-1:0] rem_in [cmds_pkg::DivStages];
  logic [cmds_pkg::DenW-1:0] den_in [cmds_pkg::DivStages];
  logic [cmds_pkg::QuoW-1:0] quo_in [cmds_pkg::DivStages];

  logic [cmds_pkg::NumW-1:0] rem_next [cmds_pkg::DivStages];
  logic [cmds_pkg::QuoW-1:0] quo_next [cmds_pkg::DivStages];

  // Stage inputs: the operands for the first stage, the previous stage after that
  always_comb begin
    rem_in[0] = num;
    den_in[0] = den;
    quo_in[0] = '0;
    for (int k = 1; k < cmds_pkg::DivStages; k++) begin
      rem_in[k] = rem_q[k-1];
      den_in[k] = den_q[k-1];
      quo_in[k] = quo_q[k-1];
    end
  end

  always_comb begin
    logic [cmds_pkg::QuoW-1:0] q;
    logic [cmds_pkg::NumW:0]   s1;
    logic [cmds_pkg::NumW:0]   s2;
    for (int k = 0; k < cmds_pkg::DivStages; k++) begin
      q  = quo_in[k];
      s1 = cmds_pkg::div_step(rem_in[k], den_in[k], 3'(7 - 2*k));
      s2 = cmds_pkg::div_step(s1[cmds_pkg::NumW-1:0], den_in[k], 3'(6 - 2*k));
      q[7 - 2*k] = s1[cmds_pkg::NumW];
      q[6 - 2*k] = s2[cmds_pkg::NumW];
      rem_next[k] = s2[cmds_pkg::NumW-1:0];
      quo_next[k] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < cmds_pkg::DivStages; k++) begin
        rem_q[k] <= rem_next[k];
        quo_q[k] <= quo_next[k];
        den_q[k] <= den_in[k];
      end
    end
  end

  assign quo = quo_q[cmds_pkg::DivStages-1];

endmodule

// ===== hw/rtl/cube_map_direction_sampler_top.sv =====
// Channel    | Direction | Contents
// s_axis     | in        | tuser: cmd; tdata: face, col, row, texel_rgb, dir_x, dir_y, dir_z
// m_axis     | out       | tuser: zero_dir; tdata: color_rgb, hit_face, hit_col, hit_row
// cfg        | in        | cfg_we / cfg_wdata: face_size
//
// One transaction per cycle unless the output stalls.
// Depth is set by the projection divider: four stages, two quotient bits each.
// Writes travel the same pipe and hit the texel RAM at the stage before the read
// register, so a lookup always sees every earlier write.
// Reset clears the valid bits and sets face_size to 128; the texel RAM holds garbage
// until written.
// A stalled result holds the whole pipe; s_axis_tready drops with it.
module cube_map_direction_sampler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // face[2:0] col[9:3] row[16:10] texel_rgb[40:17]
                                     // dir_x[56:41] dir_y[72:57] dir_z[88:73], zero pad
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // color_rgb[23:0] hit_face[26:24] hit_col[33:27]
                                     // hit_row[40:34], zero pad
  output logic        m_axis_tuser   // zero_dir
);

  logic        en;
  logic [7:0]  face_size;
  logic [7:0]  s_clamp;

  // Configuration register; clamp to 1 .. FaceSize
  always_ff @(posedge clk) begin
    if (rst) begin
      face_size <= 8'(cmds_pkg::FaceSize);
    end else if (cfg_we) begin
      face_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (face_size == 8'd0) begin
      s_clamp = 8'd1;
    end else if (face_size > 8'(cmds_pkg::FaceSize)) begin
      s_clamp = 8'(cmds_pkg::FaceSize);
    end else begin
      s_clamp = face_size;
    end
  end

  // Advance everything unless a result is waiting
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: capture the transaction
  logic        v1;
  logic        cmd1;
  logic [2:0]  face1;
  logic [6:0]  col1;
  logic [6:0]  row1;
  logic [23:0] texel1;
  logic [15:0] dx1;
  logic [15:0] dy1;
  logic [15:0] dz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1   <= s_axis_tuser;
      face1  <= s_axis_tdata[2:0];
      col1   <= s_axis_tdata[9:3];
      row1   <= s_axis_tdata[16:10];
      texel1 <= s_axis_tdata[40:17];
      dx1    <= s_axis_tdata[56:41];
      dy1    <= s_axis_tdata[72:57];
      dz1    <= s_axis_tdata[88:73];
    end
  end

  // Stage 2: major axis, face and the two minor components
  logic signed [17:0] x;
  logic signed [17:0] y;
  logic signed [17:0] z;
  logic [15:0]        ax;
  logic [15:0]        ay;
  logic [15:0]        az;
  logic signed [17:0] ax_s;
  logic signed [17:0] ay_s;
  logic signed [17:0] az_s;
  logic [2:0]         face_sel;
  logic signed [17:0] uc_sel;
  logic signed [17:0] vc_sel;
  logic [15:0]        m_sel;

  always_comb begin
    x = 18'(signed'(dx1));
    y = -18'(signed'(dy1));
    z = 18'(signed'(dz1));
    ax_s = (x < 0) ? -x : x;
    ay_s = (y < 0) ? -y : y;
    az_s = (z < 0) ? -z : z;
    ax = ax_s[15:0];
    ay = ay_s[15:0];
    az = az_s[15:0];
    if (az_s >= ax_s && az_s >= ay_s) begin
      m_sel = az;
      if (z > 0) begin
        face_sel = cmds_pkg::FACE_POSZ; uc_sel = x;  vc_sel = y;
      end else begin
        face_sel = cmds_pkg::FACE_NEGZ; uc_sel = -x; vc_sel = y;
      end
    end else if (ay_s >= ax_s) begin
      m_sel = ay;
      if (y > 0) begin
        face_sel = cmds_pkg::FACE_POSY; uc_sel = x; vc_sel = -z;
      end else begin
        face_sel = cmds_pkg::FACE_NEGY; uc_sel = x; vc_sel = z;
      end
    end else begin
      m_sel = ax;
      if (x > 0) begin
        face_sel = cmds_pkg::FACE_POSX; uc_sel = -z; vc_sel = y;
      end else begin
        face_sel = cmds_pkg::FACE_NEGX; uc_sel = z;  vc_sel = y;
      end
    end
  end

  logic               v2;
  cmds_pkg::side_t    side2;
  logic signed [17:0] uc2;
  logic signed [17:0] vc2;
  logic [15:0]        m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2.valid   <= v1;
      side2.cmd     <= cmd1;
      side2.wr_ok   <= (face1 < 3'(cmds_pkg::NumFaces));
      side2.wr_addr <= {face1, col1, row1};
      side2.wr_data <= texel1;
      side2.zero    <= (ax_s == 18'sd0) && (ay_s == 18'sd0) && (az_s == 18'sd0);
      side2.face    <= face_sel;
      uc2           <= uc_sel;
      vc2           <= vc_sel;
      m2            <= m_sel;
    end
  end

  // Stage 3: numerators (c + m) * S and denominator 2m
  logic signed [17:0] usum;
  logic signed [17:0] vsum;
  logic [24:0]        unum_w;
  logic [24:0]        vnum_w;

  assign usum   = uc2 + 18'(signed'({2'b00, m2}));
  assign vsum   = vc2 + 18'(signed'({2'b00, m2}));
  assign unum_w = 25'(usum[16:0]) * 25'(s_clamp);
  assign vnum_w = 25'(vsum[16:0]) * 25'(s_clamp);

  logic                         v3;
  cmds_pkg::side_t              side3;
  logic [cmds_pkg::NumW-1:0]    unum3;
  logic [cmds_pkg::NumW-1:0]    vnum3;
  logic [cmds_pkg::DenW-1:0]    den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side2;
      unum3 <= unum_w[cmds_pkg::NumW-1:0];
      vnum3 <= vnum_w[cmds_pkg::NumW-1:0];
      den3  <= {m2, 1'b0};
    end
  end

  // Stages 4 to 7: dividers, sideband shifts alongside
  logic [cmds_pkg::QuoW-1:0] uquo;
  logic [cmds_pkg::QuoW-1:0] vquo;

  cmds_div u_div_col (
    .clk (clk),
    .en  (en),
    .num (unum3),
    .den (den3),
    .quo (uquo)
  );

  cmds_div u_div_row (
    .clk (clk),
    .en  (en),
    .num (vnum3),
    .den (den3),
    .quo (vquo)
  );

  logic            vd   [cmds_pkg::DivStages];
  cmds_pkg::side_t side [cmds_pkg::DivStages];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < cmds_pkg::DivStages; k++) begin
        vd[k] <= 1'b0;
      end
    end else if (en) begin
      vd[0] <= v3;
      for (int k = 1; k < cmds_pkg::DivStages; k++) begin
        vd[k] <= vd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side3;
      for (int k = 1; k < cmds_pkg::DivStages; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Stage 8: wrap quotient, write or read the texel RAM
  cmds_pkg::side_t sd;
  logic            vlast;
  logic [6:0]      colw;
  logic [6:0]      roww;
  logic            do_write;
  logic            is_lookup;

  assign sd        = side[cmds_pkg::DivStages-1];
  assign vlast     = vd[cmds_pkg::DivStages-1];
  assign colw      = (uquo == s_clamp) ? 7'd0 : uquo[6:0];
  assign roww      = (vquo == s_clamp) ? 7'd0 : vquo[6:0];
  assign do_write  = en && vlast && (sd.cmd == cmds_pkg::CMD_WRITE) && sd.wr_ok;
  assign is_lookup = vlast && (sd.cmd == cmds_pkg::CMD_LOOKUP);

  logic [23:0] texel_mem [cmds_pkg::Depth];
  logic [23:0] rd_data;
  logic [cmds_pkg::AddrW-1:0] rd_addr;

  assign rd_addr = {sd.face, colw, roww};

  always_ff @(posedge clk) begin
    if (do_write) begin
      texel_mem[sd.wr_addr] <= sd.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= texel_mem[rd_addr];
    end
  end

  logic       zero_o;
  logic [2:0] face_o;
  logic [6:0] col_o;
  logic [6:0] row_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= is_lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_o <= sd.zero;
      face_o <= sd.zero ? 3'd0 : sd.face;
      col_o  <= sd.zero ? 7'd0 : colw;
      row_o  <= sd.zero ? 7'd0 : roww;
    end
  end

  assign m_axis_tuser = zero_o;
  assign m_axis_tdata = {7'd0, row_o, col_o, face_o, (zero_o ? 24'd0 : rd_data)};

  // Checks
  a_ready_follows_stall: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_zero_blank: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 48'd0))
    else $error("zero direction result carries data");

  a_col_in_face: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |->
      ({1'b0, m_axis_tdata[33:27]} < s_clamp && {1'b0, m_axis_tdata[40:34]} < s_clamp))
    else $error("texel coordinate outside face");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[26:24] < 3'(cmds_pkg::NumFaces)))
    else $error("face index out of range");

endmodule
